// ===== rtl/core/acp_pkg.sv =====
// Shared types and constants for the alignment column pair cost unit.
`default_nettype none

package acp_pkg;

	localparam int SYM_W      = 3;
	localparam int COST_W     = 16;
	localparam int SCORE_W    = 24;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_COST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_INDEX = 1'd1;

	localparam logic OP_TABLE_WRITE = 1'b0;
	localparam logic OP_SYMBOL      = 1'b1;

	localparam logic [SYM_W-1:0] GAP_INDEX_RESET = 3'd4;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

	typedef struct packed {
		logic                     opcode;
		logic [SYM_W-1:0]         row_index;
		logic [SYM_W-1:0]         col_index;
		logic signed [COST_W-1:0] cost_value;
		logic [SYM_W-1:0]         symbol;
		logic                     last;
	} in_item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] column_score;
		logic                      overflow;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/acp_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module acp_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/acp_sat_add.sv =====
// Shared 24-bit signed saturating adder.
`default_nettype none

module acp_sat_add
	import acp_pkg::*;
(
	input  wire logic signed [SCORE_W-1:0] a,
	input  wire logic signed [SCORE_W-1:0] b,
	output logic signed      [SCORE_W-1:0] sum
);

	logic signed [SCORE_W:0] wide;

	always_comb begin
		wide = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
		if (wide[SCORE_W] == wide[SCORE_W-1]) begin
			sum = wide[SCORE_W-1:0];
		end else if (wide[SCORE_W]) begin
			sum = SCORE_MIN;
		end else begin
			sum = SCORE_MAX;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/alignment_column_pair_cost_unit.sv =====
// Top level: sum-of-pairs column scorer with linear gap charge.
// Usage:
//  - in_valid/in_ready carry in_data. A table-write transfer (opcode 0) loads
//    one signed pair cost. A symbol transfer (opcode 1) is scored against every
//    symbol already held in the column; into a full column it is dropped and
//    sets the overflow flag. A symbol item then makes one pair-table read per
//    earlier symbol through the shared saturating adder, each a stored-symbol
//    read then a table cost read, and a store step that adds it to the column.
//    in_ready is high only while the sequencer is idle, so the block takes no
//    new item until it is through with the last one.
//  - The symbol marked last adds a multiply step and a final add step, then
//    out_valid/out_ready carry the column score and overflow flag; the column
//    is cleared for the next one.
//  - The result sits in an output register; if the receiver stalls while a
//    second result is ready, the sequencer holds in its final state.
//  - Reset clears the column, the sequencer and the registers (gap_cost 0,
//    gap_index 4). The pair table is undefined until written.
//  - cfg_we/cfg_index/cfg_data write a register; the user writes only while idle, the block does not enforce it.
`default_nettype none

module alignment_column_pair_cost_unit
	import acp_pkg::*;
#(
	parameter int MAX_SEQUENCES = 16,
	parameter int ALPHABET_SIZE = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W  = $clog2(MAX_SEQUENCES + 1);
	localparam int ST_AW  = $clog2(MAX_SEQUENCES);
	localparam int TAB_D  = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int TAB_AW = $clog2(TAB_D);
	// gap count times gap cost fits PROD_W bits, below 2^23 for MAX_SEQUENCES up to 128
	localparam int PROD_W = CNT_W + CFG_DATA_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PAIR   = 3'd1;
	localparam logic [2:0] ST_COMMIT = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;

	function automatic logic in_alpha(input logic [SYM_W-1:0] s);
		return int'(s) < ALPHABET_SIZE;
	endfunction

	logic [2:0]                state_q;
	logic [CFG_DATA_W-1:0]     gap_cost_q;
	logic [SYM_W-1:0]          gap_index_q;
	logic [SYM_W-1:0]          sym_q;
	logic                      last_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          gap_q;
	logic [CNT_W-1:0]          idx_q;
	logic signed [SCORE_W-1:0] pair_sum_q;
	logic                      ovf_q;
	logic [PROD_W-1:0]         prod_q;
	logic                      v_s1, v_s2, z_s2;
	logic                      out_valid_q;
	out_item_t                 out_data_q;

	logic                      accept, issue, tab_we, out_free;
	logic [TAB_AW-1:0]         tab_waddr, tab_raddr;
	logic [SYM_W-1:0]          st_rdata;
	logic signed [COST_W-1:0]  tab_rdata;
	logic signed [SCORE_W-1:0] add_b, add_sum;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign issue     = (state_q == ST_PAIR) && (idx_q < count_q);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign tab_we    = accept && (in_data.opcode == OP_TABLE_WRITE)
	                   && in_alpha(in_data.row_index) && in_alpha(in_data.col_index);
	assign tab_waddr = TAB_AW'(in_data.row_index * ALPHABET_SIZE + in_data.col_index);
	assign tab_raddr = TAB_AW'(st_rdata * ALPHABET_SIZE + sym_q);

	acp_ram #(.DEPTH(TAB_D), .WIDTH(COST_W)) u_pair_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (in_data.cost_value),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	acp_ram #(.DEPTH(MAX_SEQUENCES), .WIDTH(SYM_W)) u_symbol_store (
		.clk   (clk),
		.we    (state_q == ST_COMMIT),
		.waddr (count_q[ST_AW-1:0]),
		.wdata (sym_q),
		.raddr (idx_q[ST_AW-1:0]),
		.rdata (st_rdata)
	);

	// second operand: table cost while pairing (zero for an out-of-alphabet pair), gap charge at the end
	always_comb begin
		if (state_q == ST_FIN) begin
			add_b = {{(SCORE_W-PROD_W){1'b0}}, prod_q};
		end else if (z_s2) begin
			add_b = '0;
		end else begin
			add_b = {{(SCORE_W-COST_W){tab_rdata[COST_W-1]}}, tab_rdata};
		end
	end

	acp_sat_add u_add (
		.a   (pair_sum_q),
		.b   (add_b),
		.sum (add_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_cost_q  <= '0;
			gap_index_q <= GAP_INDEX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAP_COST:  gap_cost_q  <= cfg_data;
				REG_GAP_INDEX: gap_index_q <= cfg_data[SYM_W-1:0];
				default: ;
			endcase
		end
	end

	// pair pipeline: s1 = stored symbol read, s2 = table cost read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			z_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			z_s2 <= !(in_alpha(st_rdata) && in_alpha(sym_q));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= in_data.symbol;
			last_q <= in_data.last;
		end
		if (state_q == ST_MUL) begin
			prod_q <= gap_q * gap_cost_q;
		end
		if (state_q == ST_FIN && out_free) begin
			out_data_q <= {add_sum, ovf_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			gap_q       <= '0;
			idx_q       <= '0;
			pair_sum_q  <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (v_s2 && state_q == ST_PAIR) begin
				pair_sum_q <= add_sum;
			end
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_data.opcode == OP_SYMBOL) begin
						idx_q <= '0;
						if (count_q < CNT_W'(MAX_SEQUENCES)) begin
							state_q <= ST_PAIR;
						end else begin
							ovf_q <= 1'b1;
							if (in_data.last) begin
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_PAIR: begin
					if (!issue && !v_s1) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					count_q <= count_q + CNT_W'(1);
					if (sym_q == gap_index_q) begin
						gap_q <= gap_q + CNT_W'(1);
					end
					state_q <= last_q ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						count_q     <= '0;
						gap_q       <= '0;
						pair_sum_q  <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the final step");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !out_ready) |=> state_q == ST_FIN)
		else $error("pending result overwritten");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SEQUENCES) && gap_q <= count_q)
		else $error("column counters out of bounds");

	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMMIT |-> !v_s1 && !v_s2 && idx_q == count_q)
		else $error("store commit before pair pipeline drained");

endmodule

`default_nettype wire

// ===== tb/sv/alignment_column_pair_cost_unit_tb.sv =====
// Self-checking testbench for the alignment column pair cost unit.
`timescale 1ns / 100ps

module alignment_column_pair_cost_unit_tb;
	import acp_pkg::*;

	localparam int MAX_SEQUENCES = 16;
	localparam int ALPHABET_SIZE = 8;
	localparam int SETTLE_CYCLES = 40;

	// Predicts column scores and holds the ones still owed by the block.
	class column_score_tracker;
		int               pair_cost [ALPHABET_SIZE*ALPHABET_SIZE];
		bit               cost_loaded [ALPHABET_SIZE*ALPHABET_SIZE];
		logic [SYM_W-1:0] held_sym [MAX_SEQUENCES];
		int               held_count;
		int               gap_tally;
		int               pair_total;
		bit               over_cap;
		int               gap_charge;
		logic [SYM_W-1:0] gap_sym;
		out_item_t        score_q [$];
		int               fails;
		int               items_seen;
		int               columns_done;
		int               over_columns;

		function new();
			held_count   = 0;
			gap_tally    = 0;
			pair_total   = 0;
			over_cap     = 1'b0;
			gap_charge   = 0;
			gap_sym      = GAP_INDEX_RESET;
			fails        = 0;
			items_seen   = 0;
			columns_done = 0;
			over_columns = 0;
			foreach (cost_loaded[i]) cost_loaded[i] = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GAP_COST: begin
					gap_charge = int'(data);
				end
				REG_GAP_INDEX: begin
					gap_sym = data[SYM_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function int clamp24(longint v);
			if (v > longint'(SCORE_MAX))
				return int'(SCORE_MAX);
			if (v < longint'(SCORE_MIN))
				return int'(SCORE_MIN);
			return int'(v);
		endfunction

		function void note_fail(string msg);
			fails++;
			if (fails <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void take_item(in_item_t it);
			out_item_t want;
			items_seen++;
			if (it.opcode == OP_TABLE_WRITE) begin
				pair_cost[{it.row_index, it.col_index}] = int'($signed(it.cost_value));
				cost_loaded[{it.row_index, it.col_index}] = 1'b1;
				return;
			end
			if (held_count < MAX_SEQUENCES) begin
				for (int i = 0; i < held_count; i++)
					pair_total = clamp24(longint'(pair_total) +
						pair_cost[{held_sym[i], it.symbol}]);
				if (it.symbol == gap_sym)
					gap_tally++;
				held_sym[held_count] = it.symbol;
				held_count++;
			end else begin
				over_cap = 1'b1;
			end
			if (!it.last)
				return;
			want.column_score = SCORE_W'(clamp24(longint'(gap_tally) *
				longint'(gap_charge) + longint'(pair_total)));
			want.overflow = over_cap;
			score_q = {score_q, want};
			columns_done++;
			if (over_cap)
				over_columns++;
			held_count = 0;
			gap_tally  = 0;
			pair_total = 0;
			over_cap   = 1'b0;
		endfunction

		function void match_score(out_item_t got);
			out_item_t want;
			if (score_q.size() == 0) begin
				note_fail($sformatf("score %0d overflow %0b with none outstanding",
					got.column_score, got.overflow));
				return;
			end
			want = score_q.pop_front();
			if (got.column_score !== want.column_score || got.overflow !== want.overflow)
				note_fail($sformatf("score %0d overflow %0b, expected %0d overflow %0b",
					got.column_score, got.overflow, want.column_score, want.overflow));
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int send_idle_pct  = 33;
	int stall_pct      = 33;
	int directed_items = 0;

	column_score_tracker book = new();

	alignment_column_pair_cost_unit #(
		.MAX_SEQUENCES(MAX_SEQUENCES),
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("alignment_column_pair_cost_unit regression: fail");
		$finish;
	end

	// Result side: sample the transfer, then pick next cycle's ready.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.match_score(out_data);
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		book.take_item(it);
	endtask

	function automatic logic signed [COST_W-1:0] pick_cost();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return COST_W'($urandom);
		endcase
	endfunction

	task automatic send_write(logic [SYM_W-1:0] r, logic [SYM_W-1:0] c,
		logic signed [COST_W-1:0] v, logic lst);
		in_item_t it;
		it.opcode     = OP_TABLE_WRITE;
		it.row_index  = r;
		it.col_index  = c;
		it.cost_value = v;
		it.symbol     = SYM_W'($urandom);
		it.last       = lst;
		send_item(it);
	endtask

	// Loads any pair entry the new symbol would read before presenting it.
	task automatic send_symbol(logic [SYM_W-1:0] s, logic lst);
		in_item_t it;
		if (book.held_count < MAX_SEQUENCES)
			for (int i = 0; i < book.held_count; i++)
				if (!book.cost_loaded[{book.held_sym[i], s}])
					send_write(book.held_sym[i], s, pick_cost(), 1'($urandom));
		it.opcode     = OP_SYMBOL;
		it.row_index  = SYM_W'($urandom);
		it.col_index  = SYM_W'($urandom);
		it.cost_value = COST_W'($urandom);
		it.symbol     = s;
		it.last       = lst;
		send_item(it);
	endtask

	task automatic run_column(int len);
		logic [SYM_W-1:0] s;
		for (int k = 0; k < len; k++) begin
			s = ($urandom_range(3) == 0) ? book.gap_sym : SYM_W'($urandom);
			if ($urandom_range(9) == 0)
				send_write(SYM_W'($urandom), SYM_W'($urandom), pick_cost(), 1'($urandom));
			send_symbol(s, k == len - 1);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (book.score_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		book.set_reg(idx, data);
	endtask

	// Upper data bits on the gap index write are junk the block must drop.
	task automatic set_config(logic [CFG_DATA_W-1:0] cost, logic [SYM_W-1:0] gap);
		cfg_write(REG_GAP_COST, cost);
		cfg_write(REG_GAP_INDEX, {(CFG_DATA_W-SYM_W)'($urandom), gap});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] phase_cost [6];
		logic [SYM_W-1:0]      phase_gap [6];
		int                    target;

		phase_cost = '{16'hFFFF, 16'h0000, CFG_DATA_W'($urandom), 16'h0001,
			CFG_DATA_W'($urandom), 16'hFFFF};
		phase_gap  = '{3'd0, 3'd7, SYM_W'($urandom), 3'd4, SYM_W'($urandom), 3'd3};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: table extremes, last on a write, lone gap, reset registers.
		send_write(3'd0, 3'd0, 16'sh7FFF, 1'b1);
		send_write(3'd7, 3'd7, 16'sh8000, 1'b0);
		send_write(3'd0, 3'd7, -16'sd1, 1'b0);
		send_write(3'd7, 3'd0, 16'sd1, 1'b0);
		send_symbol(3'd4, 1'b1);
		send_symbol(3'd0, 1'b0);
		send_symbol(3'd0, 1'b0);
		send_symbol(3'd7, 1'b0);
		send_symbol(3'd7, 1'b1);
		wait_idle();
		set_config(16'hFFFF, 3'd7);
		send_symbol(3'd7, 1'b0);
		send_symbol(3'd7, 1'b0);
		send_symbol(3'd7, 1'b1);
		directed_items = book.items_seen;

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			set_config(phase_cost[p], phase_gap[p]);
			send_idle_pct = (p == 2) ? 0 : 33;
			stall_pct     = (p == 2) ? 0 : 33;
			if (p == 0)
				run_column(MAX_SEQUENCES + 2);
			target = directed_items + (p + 1) * 135;
			while (book.items_seen < target)
				run_column(($urandom_range(9) == 0) ?
					$urandom_range(MAX_SEQUENCES + 1, MAX_SEQUENCES + 4) :
					$urandom_range(1, MAX_SEQUENCES));
		end

		in_valid <= 1'b0;
		while (book.score_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Covered %0d input transfers and %0d column scores (%0d past capacity),",
			book.items_seen, book.columns_done, book.over_columns);
		$display("over eight gap cost and gap index settings with and without stalls.");
		if (book.fails == 0 && book.score_q.size() == 0) begin
			$display("alignment_column_pair_cost_unit regression: pass");
		end else begin
			$display("%0d mismatches, %0d scores outstanding", book.fails,
				book.score_q.size());
			$display("alignment_column_pair_cost_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/acp_pkg.sv
rtl/core/acp_ram.sv
rtl/core/acp_sat_add.sv
rtl/core/alignment_column_pair_cost_unit.sv
tb/sv/alignment_column_pair_cost_unit_tb.sv
